// ===== hw/rtl/heading_unwrap_moving_average_top_macros.svh =====
// ----------------------------------------------------------------------------
// Heading unwrap assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HEADING_UNWRAP_MOVING_AVERAGE_TOP_MACROS_SVH
`define HEADING_UNWRAP_MOVING_AVERAGE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define HUM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define HUM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hum_pkg.sv =====
// ----------------------------------------------------------------------------
// Heading unwrap package
// Constants, derived widths and stage types shared by the datapath modules.
// ----------------------------------------------------------------------------
package hum_pkg;

  localparam int AVG_TAPS        = 5;
  localparam int TURN_COUNT_BITS = 11;

  localparam int SAMPLE_W  = 16;
  localparam int OUT_W     = 27;
  localparam int WRAP_STEP = 30000;
  localparam int FULL_TURN = 36000;

  // sample - bias is 17-bit signed, turns * 36000 needs TURN_COUNT_BITS + 16
  localparam int ANGLE_W   = TURN_COUNT_BITS + SAMPLE_W + 1;
  localparam int POS_W     = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
  localparam int SUM_W     = ANGLE_W + $clog2(AVG_TAPS);

  // reciprocal divide: floor(n * ceil(2^(N+l)/D) / 2^(N+l)) == floor(n / D)
  localparam int DIV_SHIFT = SUM_W + $clog2(AVG_TAPS);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = DIV_SHIFT + SUM_W;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << DIV_SHIFT) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS);
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(RECIP64);

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [SAMPLE_W:0]   diff_t;
  typedef logic signed [TURN_COUNT_BITS-1:0] turn_t;
  typedef logic signed [ANGLE_W-1:0]  angle_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [OUT_W-1:0]    out_t;

  localparam diff_t  WRAP_POS  = diff_t'(WRAP_STEP);
  localparam diff_t  WRAP_NEG  = diff_t'(-WRAP_STEP);
  localparam turn_t  TURN_MAX  = {1'b0, {(TURN_COUNT_BITS-1){1'b1}}};
  localparam turn_t  TURN_MIN  = {1'b1, {(TURN_COUNT_BITS-1){1'b0}}};
  localparam angle_t TURN_STEP = angle_t'(FULL_TURN);

  typedef struct packed {
    logic   vld;
    angle_t angle;
  } angle_stage_t;

  typedef struct packed {
    logic   vld;
    angle_t angle;
    sum_t   sum;
  } sum_stage_t;

  typedef struct packed {
    logic vld;
    out_t angle;
    out_t avg;
  } result_stage_t;

endpackage

// ===== hw/rtl/hum_unwrap.sv =====
// ----------------------------------------------------------------------------
// Heading unwrap stage
// Input register, then turn tracking and unwrapped angle into a stage register.
// ----------------------------------------------------------------------------
module hum_unwrap (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_vld,
  input  hum_pkg::sample_t      up_sample,
  output logic                  up_rdy,
  input  hum_pkg::sample_t      bias,
  output hum_pkg::angle_stage_t dn,
  input  logic                  dn_rdy
);

  logic             smp_vld_r;
  hum_pkg::sample_t smp_r;
  logic             ang_vld_r;
  hum_pkg::angle_t  ang_r;
  hum_pkg::sample_t prev_r;
  hum_pkg::turn_t   turn_r;
  hum_pkg::turn_t   turn_nxt;
  hum_pkg::angle_t  off_r;
  hum_pkg::angle_t  off_nxt;
  hum_pkg::angle_t  ang_nxt;
  hum_pkg::diff_t   diff;
  logic             s1_rdy;
  logic             s2_rdy;
  logic             mv12;

  assign s2_rdy = !ang_vld_r || dn_rdy;
  assign s1_rdy = !smp_vld_r || s2_rdy;
  assign mv12   = smp_vld_r && s2_rdy;
  assign up_rdy = s1_rdy;

  always_comb begin
    diff     = $signed({1'b0, smp_r}) - $signed({1'b0, prev_r});
    turn_nxt = turn_r;
    off_nxt  = off_r;
    if (diff > hum_pkg::WRAP_POS) begin
      if (turn_r != hum_pkg::TURN_MIN) begin
        turn_nxt = turn_r - hum_pkg::turn_t'(1);
        off_nxt  = off_r - hum_pkg::TURN_STEP;
      end
    end else if (diff < hum_pkg::WRAP_NEG) begin
      if (turn_r != hum_pkg::TURN_MAX) begin
        turn_nxt = turn_r + hum_pkg::turn_t'(1);
        off_nxt  = off_r + hum_pkg::TURN_STEP;
      end
    end
    ang_nxt = hum_pkg::angle_t'($signed({1'b0, smp_r}))
            - hum_pkg::angle_t'($signed({1'b0, bias}))
            + off_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
      ang_vld_r <= 1'b0;
      prev_r    <= '0;
      turn_r    <= '0;
      off_r     <= '0;
    end else begin
      if (s1_rdy) begin
        smp_vld_r <= up_vld;
      end
      if (s2_rdy) begin
        ang_vld_r <= smp_vld_r;
      end
      if (mv12) begin
        prev_r <= smp_r;
        turn_r <= turn_nxt;
        off_r  <= off_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && up_vld) begin
      smp_r <= up_sample;
    end
    if (mv12) begin
      ang_r <= ang_nxt;
    end
  end

  assign dn.vld   = ang_vld_r;
  assign dn.angle = ang_r;

endmodule

// ===== hw/rtl/hum_avg.sv =====
// ----------------------------------------------------------------------------
// Heading unwrap ring sum
// Ring of recent angles with a running sum updated one entry per transaction.
// ----------------------------------------------------------------------------
module hum_avg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hum_pkg::angle_stage_t up,
  output logic                  up_rdy,
  output hum_pkg::sum_stage_t   dn,
  input  logic                  dn_rdy
);

  hum_pkg::angle_t           ring_r [hum_pkg::AVG_TAPS];
  logic [hum_pkg::POS_W-1:0] pos_r;
  logic [hum_pkg::POS_W-1:0] pos_nxt;
  hum_pkg::sum_t             sum_r;
  hum_pkg::sum_t             sum_nxt;
  logic                      o_vld_r;
  hum_pkg::angle_t           o_ang_r;
  hum_pkg::sum_t             o_sum_r;
  logic                      mv;

  assign up_rdy = !o_vld_r || dn_rdy;
  assign mv     = up.vld && up_rdy;

  assign sum_nxt = sum_r - hum_pkg::sum_t'(ring_r[pos_r]) + hum_pkg::sum_t'(up.angle);
  assign pos_nxt = (pos_r == hum_pkg::POS_W'(hum_pkg::AVG_TAPS - 1)) ?
                   '0 : pos_r + hum_pkg::POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      pos_r   <= '0;
      sum_r   <= '0;
      for (int i = 0; i < hum_pkg::AVG_TAPS; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      if (up_rdy) begin
        o_vld_r <= up.vld;
      end
      if (mv) begin
        ring_r[pos_r] <= up.angle;
        pos_r         <= pos_nxt;
        sum_r         <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      o_ang_r <= up.angle;
      o_sum_r <= sum_nxt;
    end
  end

  assign dn.vld   = o_vld_r;
  assign dn.angle = o_ang_r;
  assign dn.sum   = o_sum_r;

endmodule

// ===== hw/rtl/hum_div.sv =====
// ----------------------------------------------------------------------------
// Heading unwrap mean divider
// Signed divide by the tap count, truncating toward zero, by reciprocal multiply.
// ----------------------------------------------------------------------------
module hum_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hum_pkg::sum_stage_t    up,
  output logic                   up_rdy,
  output hum_pkg::result_stage_t dn,
  input  logic                   dn_rdy
);

  logic                         a_vld_r;
  logic [hum_pkg::SUM_W-1:0]    a_mag_r;
  logic                         a_neg_r;
  hum_pkg::angle_t              a_ang_r;
  logic                         b_vld_r;
  logic [hum_pkg::PROD_W-1:0]   b_prod_r;
  logic                         b_neg_r;
  hum_pkg::angle_t              b_ang_r;
  logic                         c_vld_r;
  hum_pkg::out_t                c_ang_r;
  hum_pkg::out_t                c_avg_r;
  logic                         a_rdy;
  logic                         b_rdy;
  logic                         c_rdy;
  logic [hum_pkg::SUM_W-1:0]    mag;
  logic [hum_pkg::SUM_W-1:0]    quo;
  hum_pkg::sum_t                quo_s;

  assign c_rdy  = !c_vld_r || dn_rdy;
  assign b_rdy  = !b_vld_r || c_rdy;
  assign a_rdy  = !a_vld_r || b_rdy;
  assign up_rdy = a_rdy;

  assign mag   = up.sum[hum_pkg::SUM_W-1] ? hum_pkg::SUM_W'(-up.sum) : hum_pkg::SUM_W'(up.sum);
  assign quo   = b_prod_r[hum_pkg::DIV_SHIFT +: hum_pkg::SUM_W];
  assign quo_s = b_neg_r ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= up.vld;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
      if (c_rdy) begin
        c_vld_r <= b_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && up.vld) begin
      a_mag_r <= mag;
      a_neg_r <= up.sum[hum_pkg::SUM_W-1];
      a_ang_r <= up.angle;
    end
    if (b_rdy && a_vld_r) begin
      b_prod_r <= hum_pkg::PROD_W'(a_mag_r) * hum_pkg::PROD_W'(hum_pkg::DIV_RECIP);
      b_neg_r  <= a_neg_r;
      b_ang_r  <= a_ang_r;
    end
    if (c_rdy && b_vld_r) begin
      c_avg_r <= hum_pkg::OUT_W'(quo_s);
      c_ang_r <= hum_pkg::OUT_W'(b_ang_r);
    end
  end

  assign dn.vld   = c_vld_r;
  assign dn.angle = c_ang_r;
  assign dn.avg   = c_avg_r;

endmodule

// ===== hw/rtl/heading_unwrap_moving_average_top.sv =====
// Throughput: one transaction per cycle while out_stall is low; the chain of per-stage registers
// (input, unwrap, ring sum, magnitude, multiply, output) absorbs out_stall.
// Reset (rst_n low, synchronous): clears all stage valids, heading bias,
// previous sample, turn count, ring entries, ring position and running sum.
// ----------------------------------------------------------------------------
// Heading unwrap with moving average, top level
// Unwraps heading samples into a continuous angle and reports a boxcar mean.
// ----------------------------------------------------------------------------
module heading_unwrap_moving_average_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [hum_pkg::SAMPLE_W-1:0]     in_heading_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [hum_pkg::OUT_W-1:0] out_unwrapped_angle,
  output logic signed [hum_pkg::OUT_W-1:0] out_averaged_angle,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hum_pkg::SAMPLE_W-1:0]     cfg_heading_bias
);

  hum_pkg::sample_t       bias_r;
  logic                   unw_rdy;
  hum_pkg::angle_stage_t  unw_dn;
  logic                   avg_rdy;
  hum_pkg::sum_stage_t    avg_dn;
  logic                   div_rdy;
  hum_pkg::result_stage_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      bias_r <= cfg_heading_bias;
    end
  end

  hum_unwrap u_unwrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld    (in_valid),
    .up_sample (in_heading_sample),
    .up_rdy    (unw_rdy),
    .bias      (bias_r),
    .dn        (unw_dn),
    .dn_rdy    (avg_rdy)
  );

  hum_avg u_avg (
    .clk    (clk),
    .rst_n  (rst_n),
    .up     (unw_dn),
    .up_rdy (avg_rdy),
    .dn     (avg_dn),
    .dn_rdy (div_rdy)
  );

  hum_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .up     (avg_dn),
    .up_rdy (div_rdy),
    .dn     (res),
    .dn_rdy (!out_stall)
  );

  assign in_stall            = !unw_rdy;
  assign out_valid           = res.vld;
  assign out_unwrapped_angle = res.angle;
  assign out_averaged_angle  = res.avg;

endmodule

// ===== hw/rtl/hum_checker.sv =====
// ----------------------------------------------------------------------------
// Heading unwrap port checker
// Port-level checks on reset, stall behavior, config acceptance and mean range.
// ----------------------------------------------------------------------------
`include "heading_unwrap_moving_average_top_macros.svh"

module hum_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [hum_pkg::SAMPLE_W-1:0]     in_heading_sample,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [hum_pkg::OUT_W-1:0] out_unwrapped_angle,
  input logic signed [hum_pkg::OUT_W-1:0] out_averaged_angle,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);

  // mean of ring entries stays within the reachable angle span
  localparam logic signed [hum_pkg::OUT_W-1:0] AVG_HI = hum_pkg::OUT_W'(36893535);
  localparam logic signed [hum_pkg::OUT_W-1:0] AVG_LO = hum_pkg::OUT_W'(-36929535);

  `HUM_ASSERT_IMP(a_empty_after_reset, !$past(rst_n), !out_valid,
    "result valid right after reset")

  `HUM_ASSERT_NXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(in_heading_sample),
    "stalled sample dropped or changed")

  `HUM_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_unwrapped_angle) && $stable(out_averaged_angle),
    "stalled result dropped or changed")

  `HUM_ASSERT_IMP(a_cfg_taken, cfg_valid, cfg_ready,
    "config write refused")

  `HUM_ASSERT_IMP(a_avg_range, out_valid,
    (out_averaged_angle <= AVG_HI) && (out_averaged_angle >= AVG_LO),
    "averaged angle out of reachable range")

endmodule

bind heading_unwrap_moving_average_top hum_checker u_hum_checker (.*);
